// File: rtl/core/wshc_pkg.sv
// Shared constants, types and codes for the word stream content hash.
`timescale 1ns / 1ps

package wshc_pkg;

    localparam int WORD_W     = 64;
    localparam int HALF_W     = WORD_W / 2;
    localparam int LEN_W      = 48;
    localparam int CNT_W      = 4;
    localparam int WORD_BYTES = WORD_W / 8;

    localparam logic [WORD_W-1:0] HASH_SEED = 64'h243f6a8885a308d3;
    localparam logic [WORD_W-1:0] MIX_PRIME = 64'h9e3779b185ebca87;
    localparam logic [WORD_W-1:0] FIN_PRIME = 64'hc2b2ae3d27d4eb4f;
    localparam int MIX_SHIFT = 29;
    localparam int FIN_SHIFT = 32;

    // Front-to-back queue depth (power of two).
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // What the back end has to do with a queued word.
    typedef enum logic [1:0] {
        OP_MIX       = 2'd0,  // inner word: mix only
        OP_MIX_LAST  = 2'd1,  // full last word: mix, then finalize with zero tail
        OP_TAIL_LAST = 2'd2   // partial last word: word field holds tail + prime
    } op_kind_t;

    typedef struct packed {
        op_kind_t           kind;
        logic               seed_valid;  // first word of a message
        logic [LEN_W-1:0]   length;
        logic [WORD_W-1:0]  word;
    } wshc_item_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_MUL0 = 3'd1,
        ST_MUL1 = 3'd2,
        ST_MUL2 = 3'd3,
        ST_FOLD = 3'd4
    } back_state_t;

endpackage

// File: rtl/core/word_stream_content_hash_top.sv
// Top level of the word stream content hash: front end, queue, back end.
`timescale 1ns / 1ps

// Hashes messages sent as streams of 64-bit little-endian words.
// Input side is a queue: drive an item and raise push; it is taken on a
// clock edge where push is high and full is low. message_length is read on
// the first item of a message, tail_bytes only on the item with last_item.
// Result side is a queue too: while empty is low, digest holds the oldest
// finished hash; it is taken on an edge where pop is high.
// The front end classifies each item and writes it into a two-entry queue;
// the back end runs one 32x32 multiplier three times per 64-bit multiply
// plus one fold step, so each multiply passes through MUL0, MUL1, MUL2 and FOLD.
// A full last word runs that loop twice, mixing and then finalizing; inner
// words and partial last words run it once. A back end that has run dry
// returns to IDLE before it takes the next word. The finished hash is written
// into the digest register from FOLD, and empty falls once it is registered.
// While the receiver stalls, the finished digest stays in its register and
// the back end keeps mixing words of the next message; it holds a second
// finished hash until the first one is popped, then the queue fills and
// full rises. Reset drops all queued items and any pending digest, and the
// next item starts a new message.
module word_stream_content_hash_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [wshc_pkg::WORD_W-1:0] data_word,
    input  logic [wshc_pkg::CNT_W-1:0]  tail_bytes,
    input  logic [wshc_pkg::LEN_W-1:0]  message_length,
    input  logic                        last_item,
    output logic                        empty,
    input  logic                        pop,
    output logic [wshc_pkg::WORD_W-1:0] digest
);
    import wshc_pkg::*;

    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    wshc_item_t q_item;
    wshc_item_t q_head;

    // classify and flag the first word; tail bytes are masked and prime added here
    wshc_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .data_word      (data_word),
        .tail_bytes     (tail_bytes),
        .message_length (message_length),
        .last_item      (last_item),
        .q_full         (q_full),
        .full           (full),
        .q_push         (q_push),
        .q_item         (q_item)
    );

    wshc_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .q_full  (q_full),
        .q_empty (q_empty),
        .q_head  (q_head)
    );

    // multiply/fold sequencer and digest register
    wshc_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .digest  (digest)
    );

    // queue never written while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("item written into full queue");

    // back end only takes what is queued
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back end popped an empty queue");

    // a waiting digest is neither lost nor overwritten
    a_digest_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(digest)))
        else $error("pending digest changed before pop");

endmodule

// File: rtl/core/wshc_front.sv
// Front end: accepts input items, classifies them and builds queue entries.
`timescale 1ns / 1ps

module wshc_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [wshc_pkg::WORD_W-1:0] data_word,
    input  logic [wshc_pkg::CNT_W-1:0]  tail_bytes,
    input  logic [wshc_pkg::LEN_W-1:0]  message_length,
    input  logic                        last_item,
    input  logic                        q_full,
    output logic                        full,
    output logic                        q_push,
    output wshc_pkg::wshc_item_t        q_item
);
    import wshc_pkg::*;

    logic              inside_reg;
    logic              inside_next;
    logic              accept;
    logic [WORD_W-1:0] tail_mask;
    logic [WORD_W-1:0] tail_mix;
    op_kind_t          kind;

    assign accept = push & ~q_full;
    assign full   = q_full;
    assign q_push = accept;

    // byte i is kept when i < tail_bytes; a count of 0 gives an all-zero tail
    always_comb
    begin
        for (int i = 0; i < WORD_BYTES; i++)
        begin
            tail_mask[i*8 +: 8] = (CNT_W'(i) < tail_bytes) ? 8'hff : 8'h00;
        end
    end

    assign tail_mix = (data_word & tail_mask) + MIX_PRIME;

    always_comb
    begin
        priority if (!last_item)
            kind = OP_MIX;
        else if (tail_bytes >= CNT_W'(WORD_BYTES))
            kind = OP_MIX_LAST;
        else
            kind = OP_TAIL_LAST;
    end

    always_comb
    begin
        q_item.kind       = kind;
        q_item.seed_valid = ~inside_reg;
        q_item.length     = message_length;
        q_item.word       = (kind == OP_TAIL_LAST) ? tail_mix : data_word;
    end

    assign inside_next = accept ? ~last_item : inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inside_reg <= 1'b0;
        else
            inside_reg <= inside_next;
    end

endmodule

// File: rtl/core/wshc_queue.sv
// Short FIFO between front end and back end.
`timescale 1ns / 1ps

module wshc_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_push,
    input  wshc_pkg::wshc_item_t q_item,
    input  logic                 q_pop,
    output logic                 q_full,
    output logic                 q_empty,
    output wshc_pkg::wshc_item_t q_head
);
    import wshc_pkg::*;

    wshc_item_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign q_head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = q_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({q_push, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
            entry_reg[wr_ptr_reg] <= q_item;
    end

endmodule

// File: rtl/core/wshc_back.sv
// Back end: mix/finalize sequencer on one shared 32x32 multiplier, result register.
`timescale 1ns / 1ps

module wshc_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  wshc_pkg::wshc_item_t        q_head,
    output logic                        q_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic [wshc_pkg::WORD_W-1:0] digest
);
    import wshc_pkg::*;

    back_state_t       state_reg;
    back_state_t       state_next;
    op_kind_t          kind_reg;
    op_kind_t          kind_next;
    logic              fin_reg;
    logic              fin_next;
    logic [WORD_W-1:0] h_reg;
    logic [WORD_W-1:0] h_next;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] a_next;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] acc_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] digest_reg;
    logic [WORD_W-1:0] digest_next;

    logic [WORD_W-1:0] prime;
    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [WORD_W-1:0] prod;
    logic [WORD_W-1:0] mix_fold;
    logic [WORD_W-1:0] fin_fold;
    logic [WORD_W-1:0] chain_h;
    logic [WORD_W-1:0] base;

    assign empty  = ~out_valid_reg;
    assign digest = digest_reg;

    assign prime = fin_reg ? FIN_PRIME : MIX_PRIME;

    // low 64 bits of a*prime from three partial products, one per cycle
    always_comb
    begin
        unique case (state_reg)
            ST_MUL1:
            begin
                mul_a = a_reg[WORD_W-1:HALF_W];
                mul_b = prime[HALF_W-1:0];
            end
            ST_MUL2:
            begin
                mul_a = a_reg[HALF_W-1:0];
                mul_b = prime[WORD_W-1:HALF_W];
            end
            default:
            begin
                mul_a = a_reg[HALF_W-1:0];
                mul_b = prime[HALF_W-1:0];
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign mix_fold = acc_reg ^ (acc_reg >> MIX_SHIFT);
    assign fin_fold = acc_reg ^ (acc_reg >> FIN_SHIFT);

    // running hash seen by the next word: fresh fold when chaining from ST_FOLD
    assign chain_h = (state_reg == ST_FOLD) ? mix_fold : h_reg;
    assign base    = q_head.seed_valid
                   ? (HASH_SEED ^ {{(WORD_W-LEN_W){1'b0}}, q_head.length})
                   : chain_h;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        fin_next       = fin_reg;
        h_next         = h_reg;
        a_next         = a_reg;
        acc_next       = acc_reg;
        digest_next    = digest_reg;
        out_valid_next = out_valid_reg & ~pop;
        q_pop          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    kind_next  = q_head.kind;
                    fin_next   = (q_head.kind == OP_TAIL_LAST);
                    a_next     = base ^ q_head.word;
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0:
            begin
                acc_next   = prod;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                acc_next   = acc_reg + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                acc_next   = acc_reg + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                priority if (fin_reg)
                begin
                    // hold the finished hash until the result register is free
                    if (!out_valid_reg || pop)
                    begin
                        digest_next    = fin_fold;
                        out_valid_next = 1'b1;
                        h_next         = '0;
                        state_next     = ST_IDLE;
                    end
                end
                else if (kind_reg == OP_MIX_LAST)
                begin
                    // full last word: zero tail, so only the prime is mixed in
                    a_next     = mix_fold ^ MIX_PRIME;
                    fin_next   = 1'b1;
                    state_next = ST_MUL0;
                end
                else
                begin
                    h_next = mix_fold;
                    if (!q_empty)
                    begin
                        q_pop      = 1'b1;
                        kind_next  = q_head.kind;
                        fin_next   = (q_head.kind == OP_TAIL_LAST);
                        a_next     = base ^ q_head.word;
                        state_next = ST_MUL0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= OP_MIX;
            fin_reg       <= 1'b0;
            h_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            fin_reg       <= fin_next;
            h_reg         <= h_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        acc_reg    <= acc_next;
        digest_reg <= digest_next;
    end

endmodule

// File: test/word_hash_checker.sv
// Checker for the word stream content hash: predicts digests and compares them.
`timescale 1ns / 1ps

module word_hash_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic                        full,
    input  logic [wshc_pkg::WORD_W-1:0] data_word,
    input  logic [wshc_pkg::CNT_W-1:0]  tail_bytes,
    input  logic [wshc_pkg::LEN_W-1:0]  message_length,
    input  logic                        last_item,
    input  logic                        empty,
    input  logic                        pop,
    input  logic [wshc_pkg::WORD_W-1:0] digest,
    output int                          fail_count,
    output int                          digests_pending
);
    import wshc_pkg::*;

    logic [WORD_W-1:0] hash_acc;
    bit                in_message;
    logic [WORD_W-1:0] digest_q[$];
    int                errors;

    // xor in, multiply by the mix prime, fold by 29
    function automatic logic [WORD_W-1:0] mix_in(input logic [WORD_W-1:0] h,
                                                 input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] m;
        m = (h ^ w) * MIX_PRIME;
        return m ^ (m >> MIX_SHIFT);
    endfunction

    // last item: full word (count 8..15) is mixed, else zero-padded tail
    function automatic logic [WORD_W-1:0] finish_digest(input logic [WORD_W-1:0] h,
                                                        input logic [WORD_W-1:0] w,
                                                        input logic [CNT_W-1:0] cnt);
        logic [WORD_W-1:0] f;
        logic [WORD_W-1:0] tail;
        f    = h;
        tail = '0;
        if (cnt >= WORD_BYTES)
            f = mix_in(h, w);
        else if (cnt != 0)
            tail = w & ((64'd1 << (cnt * 8)) - 64'd1);
        f = (f ^ (tail + MIX_PRIME)) * FIN_PRIME;
        return f ^ (f >> FIN_SHIFT);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [WORD_W-1:0] wanted;
        logic [WORD_W-1:0] seed;
        if (!rst_n)
        begin
            hash_acc   = '0;
            in_message = 1'b0;
            digest_q.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                if (digest_q.size() == 0)
                begin
                    $display("%0t: digest expected none, actual %h", $time, digest);
                    errors++;
                end
                else
                begin
                    wanted = digest_q.pop_front();
                    if (digest !== wanted)
                    begin
                        $display("%0t: digest expected %h, actual %h", $time, wanted, digest);
                        errors++;
                    end
                end
            end
            if (push && !full)
            begin
                seed = in_message ? hash_acc : (HASH_SEED ^ {16'h0, message_length});
                if (last_item)
                begin
                    digest_q.push_back(finish_digest(seed, data_word, tail_bytes));
                    hash_acc   = '0;
                    in_message = 1'b0;
                end
                else
                begin
                    hash_acc   = mix_in(seed, data_word);
                    in_message = 1'b1;
                end
            end
        end
        fail_count      <= errors;
        digests_pending <= digest_q.size();
    end

endmodule

// File: test/tb.sv
// Testbench top for the word stream content hash: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb;
    import wshc_pkg::*;

    // Random part size, run limit and settle time after the last digest.
    // Slowest item: the hashing loop run twice, the longest sender gap and the
    // longest receiver stall; the limit covers that several times over.
    localparam int RANDOM_ITEMS = 1350;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int SETTLE       = 40;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [WORD_W-1:0] data_word;
    logic [CNT_W-1:0]  tail_bytes;
    logic [LEN_W-1:0]  message_length;
    logic              last_item;
    logic              empty;
    logic              pop;
    logic [WORD_W-1:0] digest;

    int fail_count;
    int digests_pending;
    int cycle_count = 0;
    int items_sent  = 0;
    bit drain_mode  = 1'b0;

    word_stream_content_hash_top i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_word      (data_word),
        .tail_bytes     (tail_bytes),
        .message_length (message_length),
        .last_item      (last_item),
        .empty          (empty),
        .pop            (pop),
        .digest         (digest)
    );

    // Checker sits beside the block and only watches its ports.
    word_hash_checker i_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .data_word       (data_word),
        .tail_bytes      (tail_bytes),
        .message_length  (message_length),
        .last_item       (last_item),
        .empty           (empty),
        .pop             (pop),
        .digest          (digest),
        .fail_count      (fail_count),
        .digests_pending (digests_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a hang or a lost digest ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Drive one item at the falling edge and hold it until the block takes it.
    // push is only ever raised here, so a back-to-back item never toggles it.
    task automatic send_item(input logic [WORD_W-1:0] w, input logic [CNT_W-1:0] cnt,
                             input logic [LEN_W-1:0] len, input logic lst);
        @(negedge clk);
        push           <= 1'b1;
        data_word      <= w;
        tail_bytes     <= cnt;
        message_length <= len;
        last_item      <= lst;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop push for a number of cycles; zero keeps the stream back to back.
    task automatic idle_input(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Receiver: runs of pop high, broken by stalls that are mostly short and
    // now and then long. During the final drain pop stays high.
    initial
    begin
        int run_len;
        pop = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (drain_mode || $urandom_range(0, 99) < 65)
            begin
                pop     <= 1'b1;
                run_len = $urandom_range(1, 24);
            end
            else
            begin
                pop     <= 1'b0;
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                      : $urandom_range(1, 3);
            end
            repeat (run_len - 1) @(negedge clk);
        end
    end

    initial
    begin
        int                n_words;
        int                roll;
        int                gap;
        bit                quiet;
        logic [CNT_W-1:0]  tail;
        logic [LEN_W-1:0]  len;
        logic [WORD_W-1:0] w;

        rst_n          = 1'b0;
        push           = 1'b0;
        data_word      = '0;
        tail_bytes     = '0;
        message_length = '0;
        last_item      = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // ---------------- directed items ----------------
        // empty message: one last item with a zero-byte tail
        send_item('0, 4'd0, '0, 1'b1);
        // zero-byte tail: the word must not leak in; longest stated length
        send_item('1, 4'd0, '1, 1'b1);
        idle_input(2);
        // single full word, then tail counts above eight act as full
        send_item(64'h0123456789abcdef, 4'd8, 48'd8, 1'b1);
        send_item('1, 4'd9, 48'd8, 1'b1);
        send_item(64'hfedcba9876543210, 4'd15, '1, 1'b1);
        // every partial tail length on a single item
        for (int t = 1; t < WORD_BYTES; t++)
        begin
            send_item(64'h8877665544332211 ^ {8{8'(t)}}, CNT_W'(t), LEN_W'(t), 1'b1);
            idle_input(t % 3);
        end
        // three words: tail on inner items and length on later items are ignored
        send_item('1, 4'd15, 48'd24, 1'b0);
        send_item('0, 4'd5, '1, 1'b0);
        send_item('1, 4'd8, '0, 1'b1);
        // length that does not match the words sent
        send_item('0, 4'd0, '1, 1'b0);
        send_item(64'h00000a0b0c0d0e0f, 4'd5, 48'd5, 1'b1);
        idle_input(5);
        // alternating bit patterns, partial tail of seven
        send_item(64'haaaaaaaaaaaaaaaa, 4'd3, 48'd31, 1'b0);
        send_item(64'h5555555555555555, 4'd0, 48'h5555_5555_5555, 1'b0);
        send_item(64'haaaaaaaaaaaaaaaa, 4'd1, 48'haaaa_aaaa_aaaa, 1'b0);
        send_item(64'h5555555555555555, 4'd7, 48'd0, 1'b1);

        // ---------------- random messages ----------------
        // Mostly short messages, some medium, a few long. About one in five
        // goes back to back so stretches without gaps occur too.
        while (items_sent < RANDOM_ITEMS + 25)
        begin
            roll    = $urandom_range(0, 99);
            n_words = (roll < 60) ? $urandom_range(1, 4)
                    : (roll < 90) ? $urandom_range(5, 12) : $urandom_range(13, 40);
            tail    = ($urandom_range(0, 9) < 7) ? CNT_W'($urandom_range(0, 8))
                                                 : CNT_W'($urandom_range(9, 15));
            roll    = $urandom_range(0, 99);
            if (roll < 40)
                len = LEN_W'((n_words - 1) * WORD_BYTES + ((tail >= WORD_BYTES) ? WORD_BYTES : tail));
            else if (roll < 60)
                len = $urandom_range(0, 1) ? '1 : '0;
            else
                len = {16'($urandom_range(0, 65535)), 32'($urandom)};
            quiet = ($urandom_range(0, 4) == 0);

            for (int i = 0; i < n_words; i++)
            begin
                roll = $urandom_range(0, 99);
                w    = (roll < 10) ? '0 : (roll < 20) ? '1 : {32'($urandom), 32'($urandom)};
                // fields that the block must ignore get junk
                send_item(w,
                          (i == n_words - 1) ? tail : CNT_W'($urandom_range(0, 15)),
                          (i == 0) ? len : {16'($urandom_range(0, 65535)), 32'($urandom)},
                          i == n_words - 1);
                roll = $urandom_range(0, 99);
                gap  = quiet ? 0 : (roll < 55) ? 0 : (roll < 90) ? $urandom_range(1, 3)
                                                                 : $urandom_range(8, 40);
                idle_input(gap);
            end
        end

        // ---------------- drain and verdict ----------------
        @(negedge clk);
        push       <= 1'b0;
        drain_mode = 1'b1;
        while (digests_pending != 0)
            @(negedge clk);
        // keep popping a while so a stray extra digest is caught
        repeat (SETTLE) @(negedge clk);

        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
